[rtl/jqmm_pkg.sv]
// Shared types and constants for the joystick quad motor mixer.
`timescale 1ns / 1ps
`default_nettype none

package jqmm_pkg;

   // Operating mode; the encoding is also the status code sent with each result.
   typedef enum logic [1:0] {
      MODE_WAIT = 2'd0,
      MODE_FLY  = 2'd1,
      MODE_EXIT = 2'd2,
      MODE_KILL = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAL,
      ST_DIV,
      ST_SUM,
      ST_SCALE,
      ST_EMIT
   } state_type;

   // Axis order, which is also the order of the calibration register pairs.
   localparam logic [1:0] AXIS_ROLL   = 2'd0;
   localparam logic [1:0] AXIS_PITCH  = 2'd1;
   localparam logic [1:0] AXIS_YAW    = 2'd2;
   localparam logic [1:0] AXIS_HEIGHT = 2'd3;

   localparam logic [1:0] MOTOR_NORTH = 2'd0;
   localparam logic [1:0] MOTOR_SOUTH = 2'd1;
   localparam logic [1:0] MOTOR_EAST  = 2'd2;
   localparam logic [1:0] MOTOR_WEST  = 2'd3;

   localparam int CSR_INDEX_BITS = 3;
   localparam int LEVEL_BITS     = 8;
   localparam int TENTHS_BITS    = 14;

   localparam logic [LEVEL_BITS-1:0]         LEVEL_MAX  = 8'd255;
   localparam logic signed [TENTHS_BITS-1:0] STICK_MID  = 14'sd127;
   localparam logic signed [TENTHS_BITS-1:0] TENTHS_MAX = 14'sd2550;

   // floor(x / 10) == (x * 6554) >> 16 for every x in 0..2550.
   localparam logic [12:0] RECIP_TEN   = 13'd6554;
   localparam int          RECIP_SHIFT = 16;

endpackage

`default_nettype wire

[rtl/jqmm_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module jqmm_div #(
   parameter int DIVIDEND_BITS = 18,
   parameter int DIVISOR_BITS  = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output logic [DIVISOR_BITS-1:0]  remainder
);

   localparam int CNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  den_ff, den_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    trial_diff;
   logic                     fits;

   // The partial remainder stays below the divisor, so the trial is one bit wider.
   assign trial      = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/joystick_quad_motor_mixer_unit.sv]
// Top level of the joystick quad motor mixer: sequencer, calibration and mixing.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                                           Direction
// request   req_valid, req_ready, req_raw_*, req_exit_toggle, req_kill_button   in
// result    rsp_valid, rsp_ready, rsp_motor_*, rsp_status, rsp_last           out
// config    csr_we, csr_index, csr_wdata                                      in, write only
//
// A flying-mode request runs its four axes in turn through one restoring divider, then
// mixes with a sum and a scaling step per motor. An empty span or a reading below its
// minimum skips the divider. Other modes send a zeroed result without mixing. Reset is
// synchronous and restores the waiting mode and the default calibration. req_ready is high
// only while idle; a stalled result holds the block.

module joystick_quad_motor_mixer_unit #(
   parameter int RAW_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [RAW_BITS-1:0]                 req_raw_roll,
   input  logic [RAW_BITS-1:0]                 req_raw_pitch,
   input  logic [RAW_BITS-1:0]                 req_raw_yaw,
   input  logic [RAW_BITS-1:0]                 req_raw_height,
   input  logic                                req_exit_toggle,
   input  logic                                req_kill_button,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_motor_north,
   output logic [7:0]                          rsp_motor_south,
   output logic [7:0]                          rsp_motor_east,
   output logic [7:0]                          rsp_motor_west,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last,
   // calibration write port
   input  logic                                csr_we,
   input  logic [jqmm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [RAW_BITS-1:0]                 csr_wdata
);

   import jqmm_pkg::*;

   localparam int NUM_BITS = RAW_BITS + 8;

   // Control state.
   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic      pend_ff, pend_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] motor_ff, motor_in;
   logic       second_ff, second_in;

   // Calibration registers, one minimum and one maximum per axis.
   logic [RAW_BITS-1:0] lo_ff [4];
   logic [RAW_BITS-1:0] lo_in [4];
   logic [RAW_BITS-1:0] hi_ff [4];
   logic [RAW_BITS-1:0] hi_in [4];

   // Captured request and working values.
   logic [RAW_BITS-1:0]   raw_ff [4];
   logic [RAW_BITS-1:0]   raw_in [4];
   logic [LEVEL_BITS-1:0] cal_ff [4];
   logic [LEVEL_BITS-1:0] cal_in [4];
   logic                  tog_ff, tog_in;
   logic                  kill_ff, kill_in;
   logic signed [TENTHS_BITS-1:0] tenths_ff, tenths_in;
   mode_type              second_status_ff, second_status_in;

   // Result register.
   logic [LEVEL_BITS-1:0] north_ff, north_in;
   logic [LEVEL_BITS-1:0] south_ff, south_in;
   logic [LEVEL_BITS-1:0] east_ff, east_in;
   logic [LEVEL_BITS-1:0] west_ff, west_in;
   mode_type              status_ff, status_in;
   logic                  last_ff, last_in;

   // Calibration datapath.
   logic [RAW_BITS-1:0] sel_raw, sel_lo, sel_hi, span, offset;
   logic [NUM_BITS-1:0] offset_ext, scaled;
   logic                inverted;
   logic                div_start, div_done;
   logic [NUM_BITS-1:0] div_quo;
   logic [RAW_BITS-1:0] div_rem;
   logic [NUM_BITS:0]   quo_ceil;
   logic [LEVEL_BITS-1:0] div_level;

   // Mixing datapath.
   logic signed [TENTHS_BITS-1:0] thr10, pitch_term, roll_term, yaw_term, mix_term;
   logic signed [TENTHS_BITS-1:0] pitch_dev, roll_dev, yaw_dev;
   logic [24:0]                   recip_prod;
   logic [LEVEL_BITS-1:0]         level;

   assign sel_raw    = raw_ff[axis_ff];
   assign sel_lo     = lo_ff[axis_ff];
   assign sel_hi     = hi_ff[axis_ff];
   assign inverted   = (axis_ff == AXIS_PITCH) || (axis_ff == AXIS_HEIGHT);
   assign span       = sel_hi - sel_lo;
   assign offset     = sel_raw - sel_lo;
   assign offset_ext = NUM_BITS'(offset);
   // (raw - min) * 255 done as a shift and a subtract.
   assign scaled     = (offset_ext << 8) - offset_ext;

   jqmm_div #(
      .DIVIDEND_BITS(NUM_BITS),
      .DIVISOR_BITS (RAW_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled),
      .divisor  (span),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // Inverted axes round the quotient up before subtracting from full scale.
   assign quo_ceil = {1'b0, div_quo} + (NUM_BITS + 1)'(div_rem != '0);

   always_comb begin
      if (!inverted) begin
         div_level = (div_quo > NUM_BITS'(LEVEL_MAX)) ? LEVEL_MAX : div_quo[LEVEL_BITS-1:0];
      end else if (quo_ceil >= (NUM_BITS + 1)'(LEVEL_MAX)) begin
         div_level = '0;
      end else begin
         div_level = LEVEL_MAX - quo_ceil[LEVEL_BITS-1:0];
      end
   end

   // Terms of the plus-layout mix, all in tenths of a motor step.
   assign thr10      = (TENTHS_BITS'(cal_ff[AXIS_HEIGHT]) <<< 3)
                     + (TENTHS_BITS'(cal_ff[AXIS_HEIGHT]) <<< 1);
   assign pitch_dev  = STICK_MID - $signed(TENTHS_BITS'(cal_ff[AXIS_PITCH]));
   assign roll_dev   = STICK_MID - $signed(TENTHS_BITS'(cal_ff[AXIS_ROLL]));
   assign yaw_dev    = STICK_MID - $signed(TENTHS_BITS'(cal_ff[AXIS_YAW]));
   assign pitch_term = (pitch_dev <<< 2) + pitch_dev;
   assign roll_term  = (roll_dev <<< 2) + roll_dev;
   assign yaw_term   = (yaw_dev <<< 3) + yaw_dev;

   always_comb begin
      case (motor_ff)
         MOTOR_NORTH: mix_term = pitch_term + yaw_term;
         MOTOR_SOUTH: mix_term = yaw_term - pitch_term;
         MOTOR_EAST:  mix_term = roll_term - yaw_term;
         MOTOR_WEST:  mix_term = -roll_term - yaw_term;
         default:     mix_term = '0;
      endcase
   end

   // Divide the clamped sum by ten with a reciprocal multiply.
   assign recip_prod = tenths_ff[11:0] * RECIP_TEN;

   always_comb begin
      if (tenths_ff < 0) begin
         level = '0;
      end else if (tenths_ff > TENTHS_MAX) begin
         level = LEVEL_MAX;
      end else begin
         level = recip_prod[RECIP_SHIFT+LEVEL_BITS-1:RECIP_SHIFT];
      end
   end

   // Sequencer: next state and all register updates.
   always_comb begin
      state_in         = state_ff;
      mode_in          = mode_ff;
      pend_in          = pend_ff;
      axis_in          = axis_ff;
      motor_in         = motor_ff;
      second_in        = second_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      raw_in           = raw_ff;
      cal_in           = cal_ff;
      tog_in           = tog_ff;
      kill_in          = kill_ff;
      tenths_in        = tenths_ff;
      second_status_in = second_status_ff;
      north_in         = north_ff;
      south_in         = south_ff;
      east_in          = east_ff;
      west_in          = west_ff;
      status_in        = status_ff;
      last_in          = last_ff;
      div_start        = 1'b0;

      if (csr_we) begin
         if (csr_index[0]) begin
            hi_in[csr_index[2:1]] = csr_wdata;
         end else begin
            lo_in[csr_index[2:1]] = csr_wdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (mode_ff == MODE_FLY) begin
                  raw_in[AXIS_ROLL]   = req_raw_roll;
                  raw_in[AXIS_PITCH]  = req_raw_pitch;
                  raw_in[AXIS_YAW]    = req_raw_yaw;
                  raw_in[AXIS_HEIGHT] = req_raw_height;
                  tog_in              = req_exit_toggle;
                  kill_in             = req_kill_button;
                  axis_in             = AXIS_ROLL;
                  state_in            = ST_CAL;
               end else begin
                  north_in  = '0;
                  south_in  = '0;
                  east_in   = '0;
                  west_in   = '0;
                  status_in = mode_ff;
                  last_in   = 1'b1;
                  second_in = 1'b0;
                  state_in  = ST_EMIT;
                  if ((mode_ff == MODE_WAIT) && !req_exit_toggle) begin
                     mode_in = MODE_FLY;
                  end
               end
            end
         end

         ST_CAL: begin
            if (sel_hi <= sel_lo) begin
               cal_in[axis_ff] = '0;
            end else if (sel_raw < sel_lo) begin
               cal_in[axis_ff] = inverted ? LEVEL_MAX : '0;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
            if (state_in == ST_CAL) begin
               if (axis_ff == AXIS_HEIGHT) begin
                  motor_in = MOTOR_NORTH;
                  state_in = ST_SUM;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end

         ST_DIV: begin
            if (div_done) begin
               cal_in[axis_ff] = div_level;
               if (axis_ff == AXIS_HEIGHT) begin
                  motor_in = MOTOR_NORTH;
                  state_in = ST_SUM;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_CAL;
               end
            end
         end

         ST_SUM: begin
            tenths_in = thr10 + mix_term;
            state_in  = ST_SCALE;
         end

         ST_SCALE: begin
            case (motor_ff)
               MOTOR_NORTH: north_in = level;
               MOTOR_SOUTH: south_in = level;
               MOTOR_EAST:  east_in  = level;
               MOTOR_WEST:  west_in  = level;
               default:     north_in = level;
            endcase
            if (motor_ff == MOTOR_WEST) begin
               status_in = MODE_FLY;
               state_in  = ST_EMIT;
               if (pend_ff) begin
                  // Exit was asked for on the previous request: one more mixed
                  // result, then the zeroed exit result.
                  last_in          = 1'b0;
                  second_in        = 1'b1;
                  second_status_in = MODE_EXIT;
                  mode_in          = MODE_EXIT;
                  pend_in          = 1'b0;
               end else if (kill_ff) begin
                  last_in          = 1'b0;
                  second_in        = 1'b1;
                  second_status_in = MODE_KILL;
                  mode_in          = MODE_KILL;
                  pend_in          = 1'b0;
               end else begin
                  last_in   = 1'b1;
                  second_in = 1'b0;
                  pend_in   = tog_ff;
               end
            end else begin
               motor_in = motor_ff + 1'b1;
               state_in = ST_SUM;
            end
         end

         ST_EMIT: begin
            if (rsp_ready) begin
               if (second_ff) begin
                  north_in  = '0;
                  south_in  = '0;
                  east_in   = '0;
                  west_in   = '0;
                  status_in = second_status_ff;
                  last_in   = 1'b1;
                  second_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= MODE_WAIT;
         pend_ff   <= 1'b0;
         second_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            lo_ff[i] <= '0;
            hi_ff[i] <= '1;
         end
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         second_ff <= second_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
      end
      axis_ff          <= axis_in;
      motor_ff         <= motor_in;
      raw_ff           <= raw_in;
      cal_ff           <= cal_in;
      tog_ff           <= tog_in;
      kill_ff          <= kill_in;
      tenths_ff        <= tenths_in;
      second_status_ff <= second_status_in;
      north_ff         <= north_in;
      south_ff         <= south_in;
      east_ff          <= east_in;
      west_ff          <= west_in;
      status_ff        <= status_in;
      last_ff          <= last_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_motor_north = north_ff;
   assign rsp_motor_south = south_ff;
   assign rsp_motor_east  = east_ff;
   assign rsp_motor_west  = west_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire
